>>> src/srsb_pkg.sv
// ----------------------------------------------------------------------------
// srsb_pkg
// Shared types and constants for the sorted run splitter bucketer.
// ----------------------------------------------------------------------------
`default_nettype none

package srsb_pkg;

  localparam int unsigned MAX_BUCKETS    = 16;
  localparam int unsigned MAX_RUN_LENGTH = 1048576;

  localparam int unsigned NUM_SLOTS = MAX_BUCKETS - 1;
  localparam int unsigned SLOT_AW   = $clog2(NUM_SLOTS);

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned BUCKET_W = 4;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned COUNT_W  = 21;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [BUCKET_W-1:0] NS_MAX  = BUCKET_W'(NUM_SLOTS);
  localparam logic [COUNT_W-1:0]  RUN_MAX = COUNT_W'(MAX_RUN_LENGTH);
  localparam logic [COUNT_W-1:0]  OFF_MAX = COUNT_W'(MAX_RUN_LENGTH - 1);

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIN  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } res_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, RUN_MAX}) begin
      return RUN_MAX;
    end
    return s[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/sorted_run_splitter_bucketer_top.sv
// loads and run elements past the last splitter are handled on acceptance; any other
// element enters a compare state that closes buckets in turn, and a finish reports
// the remaining buckets in turn; table reads and reports are registered
// throughput: one splitter compare per cycle unless the output buffer is full
// reset clears the open bucket, its start and count and sets num_splitters to 1
// the splitter table is undefined after reset and has no clearing pass
// ----------------------------------------------------------------------------
// sorted_run_splitter_bucketer_top
// Splits an ascending run into buckets by a splitter table and reports
// each bucket's start offset and element count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_run_splitter_bucketer_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [srsb_pkg::BUCKET_W-1:0]   cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // splitter_index, value
  input  wire logic [srsb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  wire logic [srsb_pkg::CMD_W-1:0]      s_axis_tuser,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // bucket, bucket_offset, bucket_count
  output      logic [srsb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output      logic                            m_axis_tlast
);

  srsb_pkg::state_e state_q, state_d;

  logic [srsb_pkg::BUCKET_W-1:0] ns_q, ns_act;
  logic [srsb_pkg::BUCKET_W-1:0] open_bucket_q, open_bucket_d;
  logic [srsb_pkg::COUNT_W-1:0]  open_start_q, open_start_d;
  logic [srsb_pkg::COUNT_W-1:0]  open_count_q, open_count_d;
  logic [srsb_pkg::COUNT_W-1:0]  edge_q, edge_d;
  logic [srsb_pkg::VALUE_W-1:0]  value_q;

  logic                          in_acc;
  logic [srsb_pkg::CMD_W-1:0]    in_cmd;
  logic [srsb_pkg::IDX_W-1:0]    in_idx;
  logic [srsb_pkg::VALUE_W-1:0]  in_value;

  logic                          ram_we;
  logic [srsb_pkg::SLOT_AW-1:0]  ram_raddr;
  logic [srsb_pkg::VALUE_W-1:0]  ram_rdata;

  logic                          closes;
  logic                          push;
  logic                          space;
  srsb_pkg::res_t                res;
  logic [srsb_pkg::COUNT_W-1:0]  total;
  logic [srsb_pkg::COUNT_W-1:0]  off_clamped;

  assign in_cmd   = s_axis_tuser;
  assign in_idx   = s_axis_tdata[srsb_pkg::IDX_W-1:0];
  assign in_value = s_axis_tdata[srsb_pkg::IDX_W +: srsb_pkg::VALUE_W];

  assign s_axis_tready = (state_q == srsb_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ns_act = (ns_q > srsb_pkg::NS_MAX) ? srsb_pkg::NS_MAX : ns_q;

  assign ram_we = in_acc && (in_cmd == srsb_pkg::CMD_LOAD)
                  && (in_idx < srsb_pkg::NS_MAX);

  assign ram_raddr = (open_bucket_d < srsb_pkg::NS_MAX) ?
                     open_bucket_d[srsb_pkg::SLOT_AW-1:0] : '0;

  srsb_ram #(
    .DEPTH(srsb_pkg::NUM_SLOTS),
    .WIDTH(srsb_pkg::VALUE_W)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_idx[srsb_pkg::SLOT_AW-1:0]),
    .wdata_i(in_value),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign closes = (open_bucket_q < ns_act) && ($signed(value_q) > $signed(ram_rdata));
  assign total  = srsb_pkg::sat_add(open_start_q, open_count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srsb_pkg::ST_IDLE: begin
        if (in_acc && (in_cmd == srsb_pkg::CMD_DATA) && (open_bucket_q < ns_act)) begin
          state_d = srsb_pkg::ST_CMP;
        end else if (in_acc && (in_cmd == srsb_pkg::CMD_FIN)) begin
          state_d = srsb_pkg::ST_FIN;
        end
      end
      srsb_pkg::ST_CMP: begin
        if (!closes) begin
          state_d = srsb_pkg::ST_IDLE;
        end
      end
      srsb_pkg::ST_FIN: begin
        if (space && (open_bucket_q >= ns_act)) begin
          state_d = srsb_pkg::ST_IDLE;
        end
      end
      default: state_d = srsb_pkg::ST_IDLE;
    endcase
  end

  // datapath and reports
  always_comb begin
    open_bucket_d = open_bucket_q;
    open_start_d  = open_start_q;
    open_count_d  = open_count_q;
    edge_d        = edge_q;
    push          = 1'b0;
    off_clamped   = (open_start_q > srsb_pkg::OFF_MAX) ? srsb_pkg::OFF_MAX : open_start_q;
    res.bucket    = open_bucket_q;
    res.offset    = off_clamped[srsb_pkg::OFFSET_W-1:0];
    res.count     = open_count_q;
    res.last      = 1'b0;
    case (state_q)
      srsb_pkg::ST_IDLE: begin
        if (in_acc && (in_cmd == srsb_pkg::CMD_DATA) && (open_bucket_q >= ns_act)) begin
          open_count_d = srsb_pkg::sat_add(open_count_q, srsb_pkg::COUNT_W'(1));
        end
        if (in_acc && (in_cmd == srsb_pkg::CMD_FIN)) begin
          edge_d = (total == '0) ? '0 : total - srsb_pkg::COUNT_W'(1);
        end
      end
      srsb_pkg::ST_CMP: begin
        if (closes) begin
          if (space) begin
            push          = 1'b1;
            open_start_d  = total;
            open_count_d  = '0;
            open_bucket_d = open_bucket_q + srsb_pkg::BUCKET_W'(1);
          end
        end else begin
          open_count_d = srsb_pkg::sat_add(open_count_q, srsb_pkg::COUNT_W'(1));
        end
      end
      srsb_pkg::ST_FIN: begin
        res.last = (open_bucket_q >= ns_act);
        if (space) begin
          push = 1'b1;
          if (open_bucket_q >= ns_act) begin
            open_bucket_d = '0;
            open_start_d  = '0;
            open_count_d  = '0;
          end else begin
            open_bucket_d = open_bucket_q + srsb_pkg::BUCKET_W'(1);
            open_start_d  = edge_q;
            open_count_d  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= srsb_pkg::ST_IDLE;
      ns_q          <= srsb_pkg::BUCKET_W'(1);
      open_bucket_q <= '0;
      open_start_q  <= '0;
      open_count_q  <= '0;
    end else begin
      state_q       <= state_d;
      open_bucket_q <= open_bucket_d;
      open_start_q  <= open_start_d;
      open_count_q  <= open_count_d;
      if (cfg_we_i) begin
        ns_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
    if (in_acc) begin
      value_q <= in_value;
    end
  end

  srsb_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .res_i        (res),
    .space_o      (space),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!m_axis_tvalid || m_axis_tready))
    else $error("report pushed into a full output register");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_count_q <= srsb_pkg::RUN_MAX) && (open_start_q <= srsb_pkg::RUN_MAX))
    else $error("run count or start past saturation");

  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srsb_pkg::ST_FIN && push && res.last) |=>
      (state_q == srsb_pkg::ST_IDLE && open_bucket_q == '0 && open_count_q == '0))
    else $error("finish did not clear the open bucket");

  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srsb_pkg::ST_CMP && push) |-> (open_bucket_q < ns_act && !res.last))
    else $error("bucket closed past the last splitter");

endmodule

`default_nettype wire

>>> src/srsb_ram.sv
// ----------------------------------------------------------------------------
// srsb_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srsb_ram #(
  parameter int unsigned DEPTH = 15,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/srsb_obuf.sv
// ----------------------------------------------------------------------------
// srsb_obuf
// Output register for bucket reports on the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module srsb_obuf (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  input  wire srsb_pkg::res_t                    res_i,
  output      logic                              space_o,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output      logic [srsb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output      logic                              m_axis_tlast
);

  logic           valid_q, valid_d;
  srsb_pkg::res_t res_q;

  assign space_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {3'b000, res_q.count, res_q.offset, res_q.bucket};

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives splitter loads, ascending runs and finish commands into the sorted
// run splitter bucketer. A local bucket predictor works out every report,
// and each output word is checked field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import srsb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PRESS_CYCLES = 500;
  localparam int unsigned RANDOM_WORDS = 450;
  localparam int VAL_MIN = -2147483647 - 1;
  localparam int VAL_MAX = 2147483647;
  localparam int unsigned OFF_LSB = BUCKET_W;
  localparam int unsigned CNT_LSB = BUCKET_W + OFFSET_W;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
  } srsb_word_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } bucket_rpt_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_PULSE
  } rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [BUCKET_W-1:0]   cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // splitter_index, value
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // command
  logic [CMD_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // bucket, bucket_offset, bucket_count
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // predictor state
  logic [VALUE_W-1:0]  splitter_mem [NUM_SLOTS];
  logic [BUCKET_W-1:0] num_split  = BUCKET_W'(1);
  int unsigned         cur_bucket = 0;
  int unsigned         cur_start  = 0;
  int unsigned         cur_count  = 0;

  bucket_rpt_t bucket_reports_q[$];
  srsb_word_t  word_q[$];

  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned live_words   = 0;
  int unsigned reports_seen = 0;
  int unsigned settings_cnt = 0;
  int unsigned err_cnt      = 0;

  srsb_word_t  drv_word = '0;
  logic        drv_take, drv_offer;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  logic        rx_ready;

  sorted_run_splitter_bucketer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned run_sat(input int unsigned s);
    return (s > MAX_RUN_LENGTH) ? MAX_RUN_LENGTH : s;
  endfunction

  task automatic report_bucket(input int unsigned b, input int unsigned off,
                               input int unsigned cnt, input logic last);
    bucket_rpt_t r;
    if (off > MAX_RUN_LENGTH - 1) off = MAX_RUN_LENGTH - 1;
    r.bucket = BUCKET_W'(b);
    r.offset = OFFSET_W'(off);
    r.count  = COUNT_W'(cnt);
    r.last   = last;
    bucket_reports_q.push_back(r);
  endtask

  task automatic predict_buckets(input srsb_word_t w);
    int unsigned total, edge_off, b;
    case (w.cmd)
      CMD_LOAD: begin
        if (w.idx < NUM_SLOTS) splitter_mem[w.idx] = w.value;
      end
      CMD_DATA: begin
        while (cur_bucket < num_split &&
               $signed(w.value) > $signed(splitter_mem[cur_bucket])) begin
          report_bucket(cur_bucket, cur_start, cur_count, 1'b0);
          cur_start  = run_sat(cur_start + cur_count);
          cur_count  = 0;
          cur_bucket = cur_bucket + 1;
        end
        cur_count = run_sat(cur_count + 1);
      end
      CMD_FIN: begin
        total    = run_sat(cur_start + cur_count);
        edge_off = (total == 0) ? 0 : total - 1;
        report_bucket(cur_bucket, cur_start, cur_count, cur_bucket >= num_split);
        for (b = cur_bucket + 1; b <= num_split; b++) begin
          report_bucket(b, edge_off, 0, b == num_split);
        end
        cur_bucket = 0;
        cur_start  = 0;
        cur_count  = 0;
      end
      default: ;
    endcase
  endtask

  task automatic check_report();
    bucket_rpt_t want;
    if (bucket_reports_q.size() == 0) begin
      $error("bucket report with none expected: tdata %h tlast %b",
             m_axis_tdata, m_axis_tlast);
      err_cnt++;
    end else begin
      want = bucket_reports_q.pop_front();
      reports_seen++;
      if (m_axis_tdata[BUCKET_W-1:0] !== want.bucket) begin
        $error("bucket: expected %0d, got %0d", want.bucket, m_axis_tdata[BUCKET_W-1:0]);
        err_cnt++;
      end
      if (m_axis_tdata[OFF_LSB +: OFFSET_W] !== want.offset) begin
        $error("bucket_offset: expected %0d, got %0d", want.offset,
               m_axis_tdata[OFF_LSB +: OFFSET_W]);
        err_cnt++;
      end
      if (m_axis_tdata[CNT_LSB +: COUNT_W] !== want.count) begin
        $error("bucket_count: expected %0d, got %0d", want.count,
               m_axis_tdata[CNT_LSB +: COUNT_W]);
        err_cnt++;
      end
      if (m_axis_tlast !== want.last) begin
        $error("last_bucket: expected %0d, got %0d", want.last, m_axis_tlast);
        err_cnt++;
      end
    end
  endtask

  // sender: bursts of words with gaps between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      drv_take  = s_axis_tvalid && s_axis_tready;
      drv_offer = s_axis_tvalid && !drv_take;
      if (drv_take) begin
        predict_buckets(drv_word);
        words_taken++;
      end
      if (!drv_offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (word_q.size() > 0) begin
          drv_word  = word_q.pop_front();
          drv_offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      s_axis_tvalid <= drv_offer;
      s_axis_tdata  <= {4'b0, drv_word.value, drv_word.idx};
      s_axis_tuser  <= drv_word.cmd;
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left <= PRESS_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_report();
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FREE:   rx_ready = 1'b1;
        RX_COIN:   rx_ready = 1'($urandom_range(0, 1));
        RX_SPARSE: rx_ready = ($urandom_range(0, 7) != 0);
        default:   rx_ready = (rx_left % 8) < 3;
      endcase
      m_axis_tready <= rx_ready && (hold_left == 0);
    end
  end

  task automatic push_word(input logic [CMD_W-1:0] cmd, input int unsigned idx,
                           input int v);
    srsb_word_t w;
    w.cmd   = cmd;
    w.idx   = IDX_W'(idx);
    w.value = v;
    word_q.push_back(w);
    words_queued++;
    if (cmd != CMD_NOP && !(cmd == CMD_LOAD && idx >= NUM_SLOTS)) live_words++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (words_taken != words_queued || bucket_reports_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_num_split(input int unsigned n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= BUCKET_W'(n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    num_split = BUCKET_W'(n);
    settings_cnt++;
  endtask

  initial begin : stimulus
    int unsigned phase, n, n_runs, r, run_len, k;
    int vals[$];
    int split_vals[$];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full table with both extremes, ignored words, default setting
    for (k = 0; k < NUM_SLOTS; k++) begin
      if (k == 0) push_word(CMD_LOAD, k, VAL_MIN);
      else if (k == NUM_SLOTS - 1) push_word(CMD_LOAD, k, VAL_MAX);
      else push_word(CMD_LOAD, k, $signed(32'h8000_0000 + k * 32'h1100_0000));
    end
    push_word(CMD_LOAD, NUM_SLOTS, 0);
    push_word(CMD_NOP, 4'hF, -1);
    push_word(CMD_DATA, 0, 0);
    push_word(CMD_FIN, 0, 0);
    wait_drained();
    write_num_split(NUM_SLOTS);
    // empty run, then a run ending on a bucket edge
    push_word(CMD_FIN, 0, 0);
    push_word(CMD_DATA, 0, VAL_MIN);
    push_word(CMD_DATA, 0, VAL_MAX);
    push_word(CMD_DATA, 0, VAL_MAX);
    push_word(CMD_FIN, 0, 0);

    phase = 0;
    while (live_words < RANDOM_WORDS) begin
      wait_drained();
      case (phase)
        0:       n = 0;
        1, 2:    n = NUM_SLOTS;
        default: n = $urandom_range(0, NUM_SLOTS);
      endcase
      write_num_split(n);
      if (phase == 2) hold_req <= 1'b1;
      if (phase < 3 || $urandom_range(0, 3) != 0) begin
        split_vals.delete();
        for (k = 0; k < n; k++) split_vals.push_back(int'($urandom()));
        split_vals.sort();
        foreach (split_vals[i]) push_word(CMD_LOAD, i, split_vals[i]);
      end
      n_runs = (phase == 2) ? 24 : $urandom_range(1, 4);
      for (r = 0; r < n_runs; r++) begin
        run_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 20);
        vals.delete();
        for (k = 0; k < run_len; k++) begin
          if (split_vals.size() > 0 && $urandom_range(0, 2) == 0)
            vals.push_back(split_vals[$urandom_range(0, split_vals.size() - 1)]
                           + int'($urandom_range(0, 2)) - 1);
          else
            vals.push_back(int'($urandom()));
        end
        vals.sort();
        foreach (vals[i]) begin
          case ($urandom_range(0, 19))
            0: push_word(CMD_NOP, $urandom_range(0, 15), $urandom());
            1: push_word(CMD_LOAD, NUM_SLOTS, $urandom());
            2: push_word(CMD_LOAD, $urandom_range(0, NUM_SLOTS - 1), $urandom());
            3: push_word(CMD_DATA, $urandom_range(0, 15), $urandom());
            default: ;
          endcase
          push_word(CMD_DATA, $urandom_range(0, 15), vals[i]);
        end
        // now and then the run stays open into the next setting
        if (r < n_runs - 1 || $urandom_range(0, 3) != 0)
          push_word(CMD_FIN, $urandom_range(0, 15), $urandom());
      end
      phase++;
    end

    wait_drained();
    $display("summary: %0d words accepted, %0d bucket reports checked",
             words_taken, reports_seen);
    $display("summary: %0d num_splitters settings, long receiver hold-off %s",
             settings_cnt, hold_done ? "seen" : "missed");
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

>>> filelist.f
src/srsb_pkg.sv
src/srsb_ram.sv
src/srsb_obuf.sv
src/sorted_run_splitter_bucketer_top.sv
bench/tb_top.sv
